// ===== hdl/svmc_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// svmc_pkg
// Shared types and constants of the supply voltage mode controller.
// ---------------------------------------------------------------------------
package svmc_pkg;

   // field widths
   localparam int VOLT_W   = 14;
   localparam int HYST_W   = 10;
   localparam int CYCLE_W  = 11;
   localparam int DCOUNT_W = 4;
   localparam int DIGIT_W  = 4;
   localparam int SLEEP_W  = 4;
   localparam int CSR_IDX_W = 2;

   // operating modes
   typedef enum logic [1:0] {
      MODE_STARTUP = 2'd0,
      MODE_LOW     = 2'd1,
      MODE_MID     = 2'd2,
      MODE_HIGH    = 2'd3
   } mode_type;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_MID_THRESHOLD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HYSTERESIS = 2'd2;

   // register reset values
   localparam logic [VOLT_W-1:0] MID_THRESHOLD_RST   = 14'd3000;
   localparam logic [VOLT_W-1:0] HIGH_THRESHOLD_RST  = 14'd3600;
   localparam logic [HYST_W-1:0] HALF_HYSTERESIS_RST = 10'd50;

   // watchdog sleep codes
   localparam logic [SLEEP_W-1:0] SLEEP_NONE = 4'd0;
   localparam logic [SLEEP_W-1:0] SLEEP_HIGH = 4'd1;
   localparam logic [SLEEP_W-1:0] SLEEP_MID  = 4'd5;
   localparam logic [SLEEP_W-1:0] SLEEP_LOW  = 4'd8;

   // cadence constants
   localparam logic [CYCLE_W-1:0]  LOW_SAMPLE_PERIOD  = 11'd1200;
   localparam logic [CYCLE_W-1:0]  HIGH_SAMPLE_PERIOD = 11'd15;
   localparam logic [CYCLE_W-1:0]  LOW_STEP           = 11'd8;
   localparam logic [CYCLE_W-1:0]  CYCLE_MAX          = 11'd2047;
   localparam logic [DCOUNT_W-1:0] DISPLAY_PERIOD     = 4'd8;
   localparam logic [VOLT_W-1:0]   VCC_MAX            = 14'd9999;
   localparam logic [DIGIT_W-1:0]  BLANK_DIGIT        = 4'd10;

   // reciprocal multipliers for splitting a reading below 10000 into digits
   localparam int PROD_W     = 29;
   localparam int RECIP_10   = 6554;
   localparam int SHIFT_10   = 16;
   localparam int RECIP_100  = 10486;
   localparam int SHIFT_100  = 20;
   localparam int RECIP_1000 = 16778;
   localparam int SHIFT_1000 = 24;

   // configuration register set
   typedef struct packed {
      logic [VOLT_W-1:0] mid_threshold;
      logic [VOLT_W-1:0] high_threshold;
      logic [HYST_W-1:0] half_hysteresis;
   } cfg_type;

   // result of the mode stage, ahead of digit splitting
   typedef struct packed {
      mode_type           mode_now;
      logic               sample_taken;
      logic               led_blink;
      logic               display_write;
      logic               decimal_point;
      logic               middle_dot;
      logic [SLEEP_W-1:0] sleep_code;
      logic [VOLT_W-1:0]  volt;
   } core_result_type;

endpackage : svmc_pkg
`default_nettype wire

// ===== hdl/svmc_csr.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// svmc_csr
// Threshold and hysteresis registers behind the configuration write port.
// ---------------------------------------------------------------------------
module svmc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [svmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [svmc_pkg::VOLT_W-1:0]      csr_data,
   output svmc_pkg::cfg_type                     cfg
);
   import svmc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (csr_index)
            CSR_MID_THRESHOLD:   cfg_in.mid_threshold   = csr_data;
            CSR_HIGH_THRESHOLD:  cfg_in.high_threshold  = csr_data;
            CSR_HALF_HYSTERESIS: cfg_in.half_hysteresis = csr_data[HYST_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mid_threshold   <= MID_THRESHOLD_RST;
         cfg_ff.high_threshold  <= HIGH_THRESHOLD_RST;
         cfg_ff.half_hysteresis <= HALF_HYSTERESIS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : svmc_csr
`default_nettype wire

// ===== hdl/svmc_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// svmc_core
// Input register, mode state and per-tick decision logic.
// ---------------------------------------------------------------------------
module svmc_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  svmc_pkg::cfg_type                 cfg,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [svmc_pkg::VOLT_W-1:0]  req_vcc_sample,
   output logic                              res_valid,
   input  wire logic                         res_ready,
   output svmc_pkg::core_result_type         res
);
   import svmc_pkg::*;

   // input register
   logic              in_valid_ff;
   logic [VOLT_W-1:0] in_vcc_ff;
   logic              advance;

   // mode state
   mode_type            mode_ff, mode_in;
   logic [VOLT_W-1:0]   vnow_ff, vnow_in;
   logic [VOLT_W-1:0]   vbefore_ff, vbefore_in;
   logic [CYCLE_W-1:0]  mcycle_ff, mcycle_in;
   logic [DCOUNT_W-1:0] dcount_ff, dcount_in;
   logic                dot_ff, dot_in;

   // result register
   logic            res_valid_ff;
   core_result_type res_ff, res_in;

   // shared sampling terms
   logic [VOLT_W-1:0]  sat_vcc;
   logic               take;
   logic [VOLT_W-1:0]  vn, vb;
   logic [CYCLE_W-1:0] mc0;
   logic [CYCLE_W:0]   mc_low_sum, mc_high_sum;
   logic [CYCLE_W-1:0] mc_low_next, mc_high_next;
   logic               below_mid, below_high;
   logic               mid_up, mid_down, high_up, high_down;
   logic               display_due;

   // handshake
   assign advance   = in_valid_ff && (!res_valid_ff || res_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_vcc_ff <= req_vcc_sample;
      end
   end

   // sample selection and threshold compares
   always_comb begin
      sat_vcc = (in_vcc_ff > VCC_MAX) ? VCC_MAX : in_vcc_ff;
      case (mode_ff)
         MODE_LOW:  take = (mcycle_ff >= LOW_SAMPLE_PERIOD);
         MODE_HIGH: take = (mcycle_ff >= HIGH_SAMPLE_PERIOD);
         default:   take = 1'b1;
      endcase
      vn  = take ? sat_vcc : vnow_ff;
      vb  = take ? vnow_ff : vbefore_ff;
      mc0 = take ? '0 : mcycle_ff;

      mc_low_sum   = {1'b0, mc0} + {1'b0, LOW_STEP};
      mc_high_sum  = {1'b0, mc0} + (CYCLE_W+1)'(1);
      mc_low_next  = mc_low_sum[CYCLE_W] ? CYCLE_MAX : mc_low_sum[CYCLE_W-1:0];
      mc_high_next = mc_high_sum[CYCLE_W] ? CYCLE_MAX : mc_high_sum[CYCLE_W-1:0];

      below_mid  = vn < cfg.mid_threshold;
      below_high = vn < cfg.high_threshold;
      // threshold minus hysteresis moved to the other side to stay unsigned
      mid_up    = {1'b0, vn} > ({1'b0, cfg.mid_threshold} + (VOLT_W+1)'(cfg.half_hysteresis));
      mid_down  = ({1'b0, vn} + (VOLT_W+1)'(cfg.half_hysteresis)) < {1'b0, cfg.mid_threshold};
      high_up   = {1'b0, vn} > ({1'b0, cfg.high_threshold} + (VOLT_W+1)'(cfg.half_hysteresis));
      high_down = ({1'b0, vn} + (VOLT_W+1)'(cfg.half_hysteresis)) < {1'b0, cfg.high_threshold};

      display_due = (dcount_ff == DISPLAY_PERIOD);
   end

   // next state
   always_comb begin
      mode_in    = mode_ff;
      vnow_in    = vn;
      vbefore_in = vb;
      mcycle_in  = mc0;
      dcount_in  = dcount_ff;
      dot_in     = dot_ff;
      case (mode_ff)
         MODE_STARTUP: begin
            if (below_mid)       mode_in = MODE_LOW;
            else if (below_high) mode_in = MODE_MID;
            else                 mode_in = MODE_HIGH;
         end
         MODE_LOW: begin
            if (mid_up) begin
               mode_in = MODE_MID;
            end else begin
               mcycle_in = mc_low_next;
            end
         end
         MODE_MID: begin
            if (mid_down) begin
               mode_in   = MODE_LOW;
               mcycle_in = CYCLE_W'(1);
            end else if (high_up) begin
               mode_in   = MODE_HIGH;
               mcycle_in = CYCLE_W'(1);
            end else begin
               dot_in = !dot_ff;
            end
         end
         MODE_HIGH: begin
            if (high_down) begin
               mode_in   = MODE_MID;
               mcycle_in = CYCLE_W'(1);
            end else begin
               // display count restarts at one after a refresh
               if (display_due) begin
                  dot_in    = !dot_ff;
                  dcount_in = DCOUNT_W'(1);
               end else begin
                  dcount_in = dcount_ff + DCOUNT_W'(1);
               end
               mcycle_in = mc_high_next;
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   // result fields
   always_comb begin
      res_in               = '0;
      res_in.mode_now      = mode_in;
      res_in.sample_taken  = take;
      res_in.volt          = vn;
      case (mode_ff)
         MODE_STARTUP: res_in.sleep_code = SLEEP_NONE;
         MODE_LOW: begin
            if (!mid_up) begin
               res_in.led_blink  = (vn <= vb);
               res_in.sleep_code = SLEEP_LOW;
            end
         end
         MODE_MID: begin
            if (!mid_down && !high_up) begin
               res_in.display_write = 1'b1;
               res_in.decimal_point = 1'b1;
               res_in.middle_dot    = !dot_ff;
               res_in.sleep_code    = SLEEP_MID;
            end
         end
         MODE_HIGH: begin
            if (!high_down) begin
               res_in.sleep_code = SLEEP_HIGH;
               if (display_due) begin
                  res_in.display_write = 1'b1;
                  res_in.decimal_point = dot_ff;
                  res_in.middle_dot    = !dot_ff;
               end
            end
         end
         default: res_in.sleep_code = SLEEP_NONE;
      endcase
   end

   // state registers, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STARTUP;
         vnow_ff    <= '0;
         vbefore_ff <= '0;
         mcycle_ff  <= '0;
         dcount_ff  <= '0;
         dot_ff     <= 1'b0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         vnow_ff    <= vnow_in;
         vbefore_ff <= vbefore_in;
         mcycle_ff  <= mcycle_in;
         dcount_ff  <= dcount_in;
         dot_ff     <= dot_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         res_valid_ff <= 1'b1;
      end else if (res_ready) begin
         res_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

`ifndef SYNTHESIS
   // stored reading is always saturated
   a_vnow_range: assert property (@(posedge clock) disable iff (reset)
      vnow_ff <= VCC_MAX)
      else $error("stored voltage above saturation limit");

   // startup mode is left after the first item and never re-entered
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_STARTUP |=> mode_ff != MODE_STARTUP)
      else $error("mode returned to startup");

   // a display refresh only happens while staying in mid or high mode
   a_display_sleep: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_ff.display_write |->
         (res_ff.sleep_code == SLEEP_MID || res_ff.sleep_code == SLEEP_HIGH))
      else $error("display write with wrong sleep code");
`endif

endmodule : svmc_core
`default_nettype wire

// ===== hdl/svmc_digits.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// svmc_digits
// Splits the shown reading into four blanked digits and holds the result.
// ---------------------------------------------------------------------------
module svmc_digits (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           res_valid,
   output logic                                res_ready,
   input  svmc_pkg::core_result_type           res,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_mode_now,
   output logic                                rsp_sample_taken,
   output logic                                rsp_led_blink,
   output logic                                rsp_display_write,
   output logic [svmc_pkg::DIGIT_W-1:0]        rsp_digit_thousands,
   output logic [svmc_pkg::DIGIT_W-1:0]        rsp_digit_hundreds,
   output logic [svmc_pkg::DIGIT_W-1:0]        rsp_digit_tens,
   output logic [svmc_pkg::DIGIT_W-1:0]        rsp_digit_ones,
   output logic                                rsp_decimal_point,
   output logic                                rsp_middle_dot,
   output logic [svmc_pkg::SLEEP_W-1:0]        rsp_sleep_code
);
   import svmc_pkg::*;

   logic [PROD_W-1:0] p10, p100, p1000;
   logic [9:0]        q10;
   logic [6:0]        q100;
   logic [3:0]        q1000;
   logic [DIGIT_W-1:0] d_th, d_hu, d_te, d_on;

   logic               rsp_valid_ff;
   logic [1:0]         mode_ff;
   logic               sample_ff, led_ff, write_ff, point_ff, dot_ff;
   logic [SLEEP_W-1:0] sleep_ff;
   logic [DIGIT_W-1:0] th_ff, hu_ff, te_ff, on_ff;
   logic               load;

   assign res_ready = !rsp_valid_ff || rsp_ready;
   assign load      = res_valid && res_ready;

   // quotients by reciprocal multiply, exact for readings below 10000
   always_comb begin
      p10   = PROD_W'(res.volt) * PROD_W'(RECIP_10);
      p100  = PROD_W'(res.volt) * PROD_W'(RECIP_100);
      p1000 = PROD_W'(res.volt) * PROD_W'(RECIP_1000);
      q10   = p10[SHIFT_10 +: 10];
      q100  = p100[SHIFT_100 +: 7];
      q1000 = p1000[SHIFT_1000 +: 4];
   end

   // digit remainders with leading-zero blanking, all zero without a write
   always_comb begin
      d_th = '0;
      d_hu = '0;
      d_te = '0;
      d_on = '0;
      if (res.display_write) begin
         d_on = DIGIT_W'(res.volt - VOLT_W'({q10, 3'b000}) - VOLT_W'({q10, 1'b0}));
         d_te = (q10 == '0) ? BLANK_DIGIT :
                DIGIT_W'(q10 - 10'({q100, 3'b000}) - 10'({q100, 1'b0}));
         d_hu = (q100 == '0) ? BLANK_DIGIT :
                DIGIT_W'(q100 - 7'({q1000, 3'b000}) - 7'({q1000, 1'b0}));
         d_th = (q1000 == '0) ? BLANK_DIGIT : q1000;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mode_ff   <= res.mode_now;
         sample_ff <= res.sample_taken;
         led_ff    <= res.led_blink;
         write_ff  <= res.display_write;
         point_ff  <= res.decimal_point;
         dot_ff    <= res.middle_dot;
         sleep_ff  <= res.sleep_code;
         th_ff     <= d_th;
         hu_ff     <= d_hu;
         te_ff     <= d_te;
         on_ff     <= d_on;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode_now        = mode_ff;
   assign rsp_sample_taken    = sample_ff;
   assign rsp_led_blink       = led_ff;
   assign rsp_display_write   = write_ff;
   assign rsp_digit_thousands = th_ff;
   assign rsp_digit_hundreds  = hu_ff;
   assign rsp_digit_tens      = te_ff;
   assign rsp_digit_ones      = on_ff;
   assign rsp_decimal_point   = point_ff;
   assign rsp_middle_dot      = dot_ff;
   assign rsp_sleep_code      = sleep_ff;

`ifndef SYNTHESIS
   // quiet display fields on items that do not refresh
   a_quiet_display: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !write_ff |->
         (th_ff == '0 && hu_ff == '0 && te_ff == '0 && on_ff == '0
          && !point_ff && !dot_ff))
      else $error("display fields set without a display write");

   // ones digit is always a real decimal digit
   a_ones_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> on_ff <= DIGIT_W'(9))
      else $error("ones digit out of range");
`endif

endmodule : svmc_digits
`default_nettype wire

// ===== hdl/supply_voltage_mode_controller.sv =====
`default_nettype none
// Pipeline: an accepted item passes the input register, the mode stage register
//   and the digit stage output register, in that order.
// Throughput: one item per cycle while rsp_ready holds; the mode state is updated once per accepted item.
// Reset: synchronous, active high; clears all valids, sets startup mode,
//   zero voltages and counters, and the threshold registers to their defaults.
// ---------------------------------------------------------------------------
// supply_voltage_mode_controller
// Supply voltage mode controller: mode selection with hysteresis, sampling
// cadence, LED pulse requests and four-digit display refresh per tick.
// ---------------------------------------------------------------------------
module supply_voltage_mode_controller (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [svmc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [svmc_pkg::VOLT_W-1:0]      csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [svmc_pkg::VOLT_W-1:0]      req_vcc_sample,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_mode_now,
   output logic                                  rsp_sample_taken,
   output logic                                  rsp_led_blink,
   output logic                                  rsp_display_write,
   output logic [svmc_pkg::DIGIT_W-1:0]          rsp_digit_thousands,
   output logic [svmc_pkg::DIGIT_W-1:0]          rsp_digit_hundreds,
   output logic [svmc_pkg::DIGIT_W-1:0]          rsp_digit_tens,
   output logic [svmc_pkg::DIGIT_W-1:0]          rsp_digit_ones,
   output logic                                  rsp_decimal_point,
   output logic                                  rsp_middle_dot,
   output logic [svmc_pkg::SLEEP_W-1:0]          rsp_sleep_code
);
   import svmc_pkg::*;

   cfg_type         cfg;
   logic            res_valid;
   logic            res_ready;
   core_result_type res;

   // configuration registers
   svmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // mode state and tick decisions
   svmc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_vcc_sample (req_vcc_sample),
      .res_valid      (res_valid),
      .res_ready      (res_ready),
      .res            (res)
   );

   // digit split and output register
   svmc_digits u_digits (
      .clock               (clock),
      .reset               (reset),
      .res_valid           (res_valid),
      .res_ready           (res_ready),
      .res                 (res),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mode_now        (rsp_mode_now),
      .rsp_sample_taken    (rsp_sample_taken),
      .rsp_led_blink       (rsp_led_blink),
      .rsp_display_write   (rsp_display_write),
      .rsp_digit_thousands (rsp_digit_thousands),
      .rsp_digit_hundreds  (rsp_digit_hundreds),
      .rsp_digit_tens      (rsp_digit_tens),
      .rsp_digit_ones      (rsp_digit_ones),
      .rsp_decimal_point   (rsp_decimal_point),
      .rsp_middle_dot      (rsp_middle_dot),
      .rsp_sleep_code      (rsp_sleep_code)
   );

endmodule : supply_voltage_mode_controller
`default_nettype wire
